/* rtl/core/stereo_reprojection_robust_cost_core_macros.svh */
// Assertion helpers for the robust cost core
`ifndef STEREO_REPROJECTION_ROBUST_COST_CORE_MACROS_SVH
`define STEREO_REPROJECTION_ROBUST_COST_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SRRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/srrc_pkg.sv */
package srrc_pkg;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_POINT = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  localparam logic [1:0] CFG_STOP_COST    = 2'd0;
  localparam logic [1:0] CFG_ROBUST_SCALE = 2'd1;

  localparam logic [5:0] TABLE_WORDS = 6'd36;
  localparam logic [5:0] MODEL_BASE  = 6'd0;
  localparam logic [5:0] LEFT_BASE   = 6'd12;
  localparam logic [5:0] RIGHT_BASE  = 6'd24;

  localparam logic signed [65:0] S66_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S66_MIN = -66'sd2147483648;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [31:0] s_xx;
    logic signed [31:0] s_xy;
    logic signed [31:0] s_yy;
  } in_item_t;

  typedef struct packed {
    logic [31:0] point_error;
    logic [31:0] robust_cost;
    logic        below_stop;
    logic        invalid_point;
    logic        skipped;
  } out_item_t;

  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S66_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S66_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/stereo_reprojection_robust_cost_core.sv */
// Robust reprojection cost of one stereo pose hypothesis. Load beats fill the 36-word
// coefficient table (model, left and right projection, signed Q with FRAC_BITS fraction
// bits), a start beat clears the running cost, and each point beat returns one result
// beat: sqrt of the Mahalanobis error, the running cost and flags. Load, start and
// config beats are taken in the idle state and leave it idle. A point beat holds the
// block while one 32x32 multiplier, fed from the table port with a read, multiply
// and accumulate step per term, and one bit-serial divide/root unit work on it; that
// unit runs eight projection divides, the root and the cost divide on NUMW-bit
// numerators, NUMW being 36+FRAC_BITS rounded down to even. A point after the stop
// limit goes straight to the finish state; a point with a zero projection depth
// stops at that depth. The input is stalled while a point is worked on; a finished
// result waits in the output register while the next beat is taken.
module stereo_reprojection_robust_cost_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  srrc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output srrc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import srrc_pkg::*;

  `include "stereo_reprojection_robust_cost_core_macros.svh"

  localparam int NUMW = 2 * ((36 + FRAC_BITS) / 2);
  localparam int CNTW = $clog2(NUMW + 1);
  localparam int REMW = 37;
  localparam logic [32:0] INC_ONE = 33'(1) << FRAC_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_ACC  = 4'd3;
  localparam logic [3:0] ST_PDIV = 4'd4;
  localparam logic [3:0] ST_PST  = 4'd5;
  localparam logic [3:0] ST_WD   = 4'd6;
  localparam logic [3:0] ST_WMUL = 4'd7;
  localparam logic [3:0] ST_WACC = 4'd8;
  localparam logic [3:0] ST_EV   = 4'd9;
  localparam logic [3:0] ST_SQRT = 4'd10;
  localparam logic [3:0] ST_SQD  = 4'd11;
  localparam logic [3:0] ST_CDIV = 4'd12;
  localparam logic [3:0] ST_COST = 4'd13;
  localparam logic [3:0] ST_FIN  = 4'd14;

  logic [3:0]            state_r;
  logic [2:0]            job_r;
  logic [1:0]            row_r;
  logic [1:0]            j_r;
  logic                  sub_r;
  logic                  side_r;
  logic [2:0]            k_r;
  logic [CNTW-1:0]       cnt_r;
  logic                  bad_r;
  logic                  neg_r;
  in_item_t              pt_r;
  logic signed [31:0]    pr_r [3];
  logic signed [31:0]    uvw_r [3];
  logic signed [31:0]    img_r [8];
  logic signed [31:0]    m_r [3];
  logic signed [31:0]    dx_r;
  logic signed [31:0]    dy_r;
  logic signed [35:0]    e_r;
  logic signed [63:0]    prod_r;
  logic signed [65:0]    acc_r;
  logic signed [31:0]    rd_r;
  logic signed [31:0]    mem [36];
  logic [NUMW-1:0]       num_r;
  logic [REMW-1:0]       rem_r;
  logic [NUMW-1:0]       quo_r;
  logic [35:0]           div_r;
  logic [31:0]           err_r;
  out_item_t             res_r;
  out_item_t             out_data_r;
  logic                  out_valid_r;
  logic [31:0]           cost_r;
  logic [31:0]           stop_r;
  logic [31:0]           scale_r;

  logic                  in_fire;
  logic signed [31:0]    pv [3];
  logic signed [31:0]    pj;
  logic [5:0]            base;
  logic [5:0]            addr;
  logic signed [31:0]    mul_a;
  logic signed [31:0]    mul_b;
  logic signed [63:0]    mul_p;
  logic signed [65:0]    prod_ext;
  logic signed [65:0]    prod_sh;
  logic signed [31:0]    qv;
  logic signed [65:0]    term;
  logic signed [65:0]    acc_nxt;
  logic signed [31:0]    rowv;
  logic                  sqrt_mode;
  logic [REMW-1:0]       rem_d;
  logic [REMW-1:0]       rem_s;
  logic [REMW-1:0]       trial;
  logic [REMW-1:0]       cmp_a;
  logic [REMW-1:0]       cmp_b;
  logic                  ge;
  logic [REMW-1:0]       diff;
  logic signed [31:0]    pres;
  logic signed [31:0]    px;
  logic signed [31:0]    pw;
  logic [32:0]           ax;
  logic [32:0]           aw;
  logic [33:0]           ue;
  logic signed [31:0]    wa_x;
  logic signed [31:0]    wa_y;
  logic signed [31:0]    wb_x;
  logic signed [31:0]    wb_y;
  logic [32:0]           inc;
  logic [33:0]           sum;
  logic [31:0]           cost_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // operand vector for the row in flight
  always_comb begin
    case (job_r)
      3'd0: begin
        pv[0] = pt_r.ref_x;
        pv[1] = pt_r.ref_y;
        pv[2] = pt_r.ref_z;
      end
      3'd1, 3'd3: begin
        pv[0] = pr_r[0];
        pv[1] = pr_r[1];
        pv[2] = pr_r[2];
      end
      default: begin
        pv[0] = pt_r.cam_x;
        pv[1] = pt_r.cam_y;
        pv[2] = pt_r.cam_z;
      end
    endcase
    case (j_r)
      2'd0:    pj = pv[0];
      2'd1:    pj = pv[1];
      default: pj = pv[2];
    endcase
    case (job_r)
      3'd0:       base = MODEL_BASE;
      3'd1, 3'd2: base = LEFT_BASE;
      default:    base = RIGHT_BASE;
    endcase
  end

  assign addr = base + 6'({row_r, j_r});

  // shared multiplier
  always_comb begin
    if (state_r == ST_MUL) begin
      mul_a = rd_r;
      mul_b = pj;
    end else begin
      case (k_r)
        3'd0: begin mul_a = dx_r;      mul_b = dx_r;   end
        3'd1: begin mul_a = dx_r;      mul_b = dy_r;   end
        3'd2: begin mul_a = dy_r;      mul_b = dy_r;   end
        3'd3: begin mul_a = pt_r.s_xx; mul_b = m_r[0]; end
        3'd4: begin mul_a = pt_r.s_xy; mul_b = m_r[1]; end
        default: begin mul_a = pt_r.s_yy; mul_b = m_r[2]; end
      endcase
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{2{prod_r[63]}}, prod_r};
  assign prod_sh  = prod_ext >>> FRAC_BITS;
  assign qv       = sat66(prod_sh);
  assign term     = (j_r == 2'd3) ? {{34{rd_r[31]}}, rd_r} : prod_sh;
  assign acc_nxt  = ((j_r == 2'd0) ? 66'sd0 : acc_r) + term;
  assign rowv     = sat66(acc_nxt);

  // shared bit-serial divide / root step
  assign sqrt_mode = (state_r == ST_SQRT);
  assign rem_d = {rem_r[REMW-2:0], num_r[NUMW-1]};
  assign rem_s = {rem_r[REMW-3:0], num_r[NUMW-1:NUMW-2]};
  assign trial = {quo_r[REMW-3:0], 2'b01};
  assign cmp_a = sqrt_mode ? rem_s : rem_d;
  assign cmp_b = sqrt_mode ? trial : {1'b0, div_r};
  assign ge    = (cmp_a >= cmp_b);
  assign diff  = cmp_a - cmp_b;

  // truncated quotient with saturation
  always_comb begin
    if (!neg_r) begin
      pres = (|quo_r[NUMW-1:31]) ? 32'sh7FFFFFFF : $signed(quo_r[31:0]);
    end else if ((|quo_r[NUMW-1:32]) || (quo_r[31] && (|quo_r[30:0]))) begin
      pres = 32'sh80000000;
    end else begin
      pres = $signed(32'd0 - quo_r[31:0]);
    end
  end

  // divide set-up: u at the end of the w row, v after u
  assign px = (state_r == ST_ACC) ? uvw_r[0] : uvw_r[1];
  assign pw = (state_r == ST_ACC) ? rowv : uvw_r[2];
  assign ax = px[31] ? (33'd0 - {1'b1, px}) : {1'b0, px};
  assign aw = pw[31] ? (33'd0 - {1'b1, pw}) : {1'b0, pw};
  assign ue = e_r[33:0];

  always_comb begin
    if (side_r) begin
      wa_x = img_r[6]; wa_y = img_r[7]; wb_x = img_r[4]; wb_y = img_r[5];
    end else begin
      wa_x = img_r[2]; wa_y = img_r[3]; wb_x = img_r[0]; wb_y = img_r[1];
    end
  end

  always_comb begin
    if (bad_r) begin
      inc = INC_ONE;
    end else if (div_r == 36'd0) begin
      inc = 33'd0;
    end else begin
      inc = quo_r[32:0];
    end
    sum      = {2'b00, cost_r} + {1'b0, inc};
    cost_nxt = sum[33:32] != 2'b00 ? 32'hFFFFFFFF : sum[31:0];
  end

  // coefficient table
  always_ff @(posedge clk) begin
    if (in_fire && in_data.req_type == REQ_LOAD && in_data.coef_index < TABLE_WORDS) begin
      mem[in_data.coef_index] <= in_data.coef_value;
    end
    if (state_r == ST_RD) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cost_r      <= 32'd0;
      stop_r      <= 32'hFFFFFFFF;
      scale_r     <= 32'(INC_ONE);
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STOP_COST) begin
          stop_r <= cfg_data;
        end else if (cfg_index == CFG_ROBUST_SCALE) begin
          scale_r <= cfg_data;
        end
      end
      if (out_valid_r && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_data.req_type == REQ_START) begin
              cost_r <= 32'd0;
            end else if (in_data.req_type == REQ_POINT) begin
              if (cost_r >= stop_r) begin
                res_r.point_error   <= 32'd0;
                res_r.robust_cost   <= cost_r;
                res_r.below_stop    <= 1'b0;
                res_r.invalid_point <= 1'b0;
                res_r.skipped       <= 1'b1;
                state_r             <= ST_FIN;
              end else begin
                pt_r    <= in_data;
                job_r   <= 3'd0;
                row_r   <= 2'd0;
                j_r     <= 2'd0;
                bad_r   <= 1'b0;
                state_r <= ST_RD;
              end
            end
          end
        end
        ST_RD: state_r <= ST_MUL;
        ST_MUL: begin
          prod_r  <= mul_p;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r <= acc_nxt;
          if (j_r != 2'd3) begin
            j_r     <= j_r + 2'd1;
            state_r <= ST_RD;
          end else begin
            j_r <= 2'd0;
            if (job_r == 3'd0) begin
              if (row_r == 2'd0) begin
                pr_r[0] <= rowv;
              end else if (row_r == 2'd1) begin
                pr_r[1] <= rowv;
              end else begin
                pr_r[2] <= rowv;
              end
              if (row_r == 2'd2) begin
                job_r <= 3'd1;
                row_r <= 2'd0;
              end else begin
                row_r <= row_r + 2'd1;
              end
              state_r <= ST_RD;
            end else if (row_r != 2'd2) begin
              if (row_r == 2'd0) begin
                uvw_r[0] <= rowv;
              end else begin
                uvw_r[1] <= rowv;
              end
              row_r   <= row_r + 2'd1;
              state_r <= ST_RD;
            end else begin
              uvw_r[2] <= rowv;
              if (rowv == 32'sd0) begin
                bad_r   <= 1'b1;
                state_r <= ST_COST;
              end else begin
                num_r   <= NUMW'(ax) << FRAC_BITS;
                div_r   <= 36'(aw);
                neg_r   <= px[31] ^ pw[31];
                rem_r   <= '0;
                quo_r   <= '0;
                cnt_r   <= CNTW'(NUMW);
                sub_r   <= 1'b0;
                state_r <= ST_PDIV;
              end
            end
          end
        end
        ST_PDIV, ST_SQRT, ST_CDIV: begin
          rem_r <= ge ? diff : cmp_a;
          quo_r <= {quo_r[NUMW-2:0], ge};
          num_r <= sqrt_mode ? (num_r << 2) : (num_r << 1);
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            if (state_r == ST_PDIV) begin
              state_r <= ST_PST;
            end else if (state_r == ST_SQRT) begin
              state_r <= ST_SQD;
            end else begin
              state_r <= ST_COST;
            end
          end
        end
        ST_PST: begin
          img_r[{2'(job_r - 3'd1), sub_r}] <= pres;
          if (!sub_r) begin
            num_r   <= NUMW'(ax) << FRAC_BITS;
            div_r   <= 36'(aw);
            neg_r   <= px[31] ^ pw[31];
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= CNTW'(NUMW);
            sub_r   <= 1'b1;
            state_r <= ST_PDIV;
          end else if (job_r == 3'd4) begin
            side_r  <= 1'b0;
            e_r     <= 36'sd0;
            state_r <= ST_WD;
          end else begin
            job_r   <= job_r + 3'd1;
            row_r   <= 2'd0;
            j_r     <= 2'd0;
            state_r <= ST_RD;
          end
        end
        ST_WD: begin
          dx_r    <= sat66({{34{wa_x[31]}}, wa_x} - {{34{wb_x[31]}}, wb_x});
          dy_r    <= sat66({{34{wa_y[31]}}, wa_y} - {{34{wb_y[31]}}, wb_y});
          k_r     <= 3'd0;
          state_r <= ST_WMUL;
        end
        ST_WMUL: begin
          prod_r  <= mul_p;
          state_r <= ST_WACC;
        end
        ST_WACC: begin
          case (k_r)
            3'd0: m_r[0] <= qv;
            3'd1: m_r[1] <= qv;
            3'd2: m_r[2] <= qv;
            3'd4: e_r <= e_r + {{3{qv[31]}}, qv, 1'b0};
            default: e_r <= e_r + {{4{qv[31]}}, qv};
          endcase
          if (k_r == 3'd5) begin
            if (side_r) begin
              state_r <= ST_EV;
            end else begin
              side_r  <= 1'b1;
              state_r <= ST_WD;
            end
          end else begin
            k_r     <= k_r + 3'd1;
            state_r <= ST_WMUL;
          end
        end
        ST_EV: begin
          if (e_r[35]) begin
            bad_r   <= 1'b1;
            state_r <= ST_COST;
          end else begin
            num_r   <= NUMW'(ue) << FRAC_BITS;
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= CNTW'(NUMW / 2);
            state_r <= ST_SQRT;
          end
        end
        ST_SQD: begin
          err_r   <= quo_r[31:0];
          num_r   <= NUMW'(ue) << FRAC_BITS;
          div_r   <= 36'(ue) + 36'(scale_r);
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= CNTW'(NUMW);
          state_r <= ST_CDIV;
        end
        ST_COST: begin
          cost_r              <= cost_nxt;
          res_r.point_error   <= bad_r ? 32'hFFFFFFFF : err_r;
          res_r.robust_cost   <= cost_nxt;
          res_r.below_stop    <= (cost_nxt < stop_r);
          res_r.invalid_point <= bad_r;
          res_r.skipped       <= 1'b0;
          state_r             <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SRRC_ASSERT_NOW(a_pdiv_nonzero, state_r == ST_PDIV, div_r != 36'd0,
    "projection divide with zero depth")
  `SRRC_ASSERT_NXT(a_cost_hold, state_r != ST_COST && state_r != ST_IDLE, $stable(cost_r),
    "cost changed outside update")
  `SRRC_ASSERT_NXT(a_out_from_fin, state_r != ST_FIN && !out_valid_r, !out_valid_r,
    "result beat without finish")
  `SRRC_ASSERT_NXT(a_fin_wait, state_r == ST_FIN && out_valid_r && out_stall,
    state_r == ST_FIN, "finish left while output blocked")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import srrc_pkg::*;

  localparam int FRAC = 16;
  localparam int ONE = 65536;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam int PHASE_ITEMS = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  stereo_reprojection_robust_cost_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  in_item_t    beat_q[$];
  out_item_t   score_q[$];
  int          coef[36];
  logic [31:0] cost_acc;
  logic [31:0] stop_lim;
  logic [31:0] sigma2;
  int          n_errors;
  longint      cycles;
  int          tx_gap_pct;
  int          rx_stall_pct;
  bit          rx_hold_req;
  int          rx_hold_cnt;
  bit          in_took;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int qmul(int a, int b);
    return sat32((longint'(a) * longint'(b)) >>> FRAC);
  endfunction

  function automatic int row_dot(int base, int p0, int p1, int p2);
    longint acc;
    acc = ((longint'(coef[base]) * p0) >>> FRAC) + ((longint'(coef[base + 1]) * p1) >>> FRAC)
        + ((longint'(coef[base + 2]) * p2) >>> FRAC) + longint'(coef[base + 3]);
    return sat32(acc);
  endfunction

  function automatic bit to_image(int base, int p0, int p1, int p2, output int ix, output int iy);
    int u, v, w;
    u = row_dot(base, p0, p1, p2);
    v = row_dot(base + 4, p0, p1, p2);
    w = row_dot(base + 8, p0, p1, p2);
    ix = 0;
    iy = 0;
    if (w == 0) return 1'b0;
    ix = sat32((longint'(u) * ONE) / longint'(w));
    iy = sat32((longint'(v) * ONE) / longint'(w));
    return 1'b1;
  endfunction

  function automatic longint maha(int ax, int ay, int bx, int by, int sxx, int sxy, int syy);
    int dx, dy;
    dx = sat32(longint'(ax) - bx);
    dy = sat32(longint'(ay) - by);
    return longint'(qmul(sxx, qmul(dx, dx))) + 2 * longint'(qmul(sxy, qmul(dx, dy)))
         + longint'(qmul(syy, qmul(dy, dy)));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic out_item_t score_point(in_item_t it);
    out_item_t r;
    int mx, my, mz, lrx, lry, lcx, lcy, rrx, rry, rcx, rcy;
    bit ok;
    longint e;
    longint unsigned ue, den, inc, err, sum;
    r = '0;
    if (cost_acc >= stop_lim) begin
      r.robust_cost = cost_acc;
      r.skipped = 1'b1;
      return r;
    end
    mx = row_dot(0, it.ref_x, it.ref_y, it.ref_z);
    my = row_dot(4, it.ref_x, it.ref_y, it.ref_z);
    mz = row_dot(8, it.ref_x, it.ref_y, it.ref_z);
    ok = to_image(int'(LEFT_BASE), mx, my, mz, lrx, lry);
    ok = to_image(int'(LEFT_BASE), it.cam_x, it.cam_y, it.cam_z, lcx, lcy) && ok;
    ok = to_image(int'(RIGHT_BASE), mx, my, mz, rrx, rry) && ok;
    ok = to_image(int'(RIGHT_BASE), it.cam_x, it.cam_y, it.cam_z, rcx, rcy) && ok;
    e = 0;
    if (ok) begin
      e = maha(lcx, lcy, lrx, lry, it.s_xx, it.s_xy, it.s_yy)
        + maha(rcx, rcy, rrx, rry, it.s_xx, it.s_xy, it.s_yy);
      if (e < 0) ok = 1'b0;
    end
    if (ok) begin
      ue = longint'(e);
      den = ue + longint'(sigma2);
      err = int_sqrt(ue << FRAC);
      if (err > 64'hFFFFFFFF) err = 64'hFFFFFFFF;
      inc = (den == 0) ? 0 : (ue << FRAC) / den;
    end else begin
      err = 64'hFFFFFFFF;
      inc = ONE;
    end
    sum = longint'(cost_acc) + inc;
    cost_acc = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
    r.point_error = err[31:0];
    r.robust_cost = cost_acc;
    r.below_stop = cost_acc < stop_lim;
    r.invalid_point = !ok;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // predictor: input side
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall && rst_n;
    if (rst_n && in_valid && !in_stall) begin
      case (in_data.req_type)
        REQ_LOAD:  if (in_data.coef_index < TABLE_WORDS) coef[in_data.coef_index] = in_data.coef_value;
        REQ_START: cost_acc = '0;
        REQ_POINT: score_q.push_back(score_point(in_data));
        default: ;
      endcase
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (score_q.size() == 0) begin
        report("unexpected beat", out_data.robust_cost, '0);
      end else begin
        want = score_q.pop_front();
        if (out_data.point_error !== want.point_error)
          report("point_error", out_data.point_error, want.point_error);
        if (out_data.robust_cost !== want.robust_cost)
          report("robust_cost", out_data.robust_cost, want.robust_cost);
        if (out_data.below_stop !== want.below_stop)
          report("below_stop", 32'(out_data.below_stop), 32'(want.below_stop));
        if (out_data.invalid_point !== want.invalid_point)
          report("invalid_point", 32'(out_data.invalid_point), 32'(want.invalid_point));
        if (out_data.skipped !== want.skipped)
          report("skipped", 32'(out_data.skipped), 32'(want.skipped));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (beat_q.size() > 0 && $urandom_range(99) >= tx_gap_pct) begin
        in_data <= beat_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold_req && rx_hold_cnt == 0) begin
      rx_hold_req <= 1'b0;
      rx_hold_cnt <= 4000;
      out_stall <= 1'b1;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < rx_stall_pct;
    end
  end

  function automatic in_item_t blank_beat(logic [1:0] req);
    in_item_t it;
    it.req_type = req;
    it.coef_index = 6'($urandom_range(63));
    it.coef_value = $urandom;
    it.ref_x = $urandom; it.ref_y = $urandom; it.ref_z = $urandom;
    it.cam_x = $urandom; it.cam_y = $urandom; it.cam_z = $urandom;
    it.s_xx = $urandom; it.s_xy = $urandom; it.s_yy = $urandom;
    return it;
  endfunction

  function automatic int srnd(int mag);
    return int'($urandom_range(0, 2 * mag * 256)) * 256 - mag * ONE;
  endfunction

  task automatic push_load(int idx, int val);
    in_item_t it;
    it = blank_beat(REQ_LOAD);
    it.coef_index = 6'(idx);
    it.coef_value = val;
    beat_q.push_back(it);
  endtask

  task automatic push_start();
    beat_q.push_back(blank_beat(REQ_START));
  endtask

  task automatic load_table(bit perturb);
    int f, b, i, r;
    for (i = 0; i < 12; i++) begin
      r = i / 4;
      if (i % 4 == 3) push_load(i, perturb ? srnd(5) : 0);
      else if (i % 4 == r) push_load(i, ONE + (perturb ? srnd(1) / 10 : 0));
      else push_load(i, perturb ? srnd(1) / 10 : 0);
    end
    f = $urandom_range(200, 800);
    b = $urandom_range(1, 5);
    for (i = 0; i < 2; i++) begin
      push_load(LEFT_BASE + 12 * i + 0, f * ONE);
      push_load(LEFT_BASE + 12 * i + 1, 0);
      push_load(LEFT_BASE + 12 * i + 2, 320 * ONE);
      push_load(LEFT_BASE + 12 * i + 3, i ? -(f * b * ONE / 10) : 0);
      push_load(LEFT_BASE + 12 * i + 4, 0);
      push_load(LEFT_BASE + 12 * i + 5, f * ONE);
      push_load(LEFT_BASE + 12 * i + 6, 240 * ONE);
      push_load(LEFT_BASE + 12 * i + 7, 0);
      push_load(LEFT_BASE + 12 * i + 8, 0);
      push_load(LEFT_BASE + 12 * i + 9, 0);
      push_load(LEFT_BASE + 12 * i + 10, ONE);
      push_load(LEFT_BASE + 12 * i + 11, 0);
    end
  endtask

  function automatic in_item_t good_point();
    in_item_t it;
    it = blank_beat(REQ_POINT);
    it.ref_x = srnd(20);
    it.ref_y = srnd(20);
    it.ref_z = int'($urandom_range(8 * ONE, 40 * ONE));
    it.cam_x = it.ref_x + srnd(1);
    it.cam_y = it.ref_y + srnd(1);
    it.cam_z = it.ref_z + srnd(1);
    it.s_xx = $urandom_range(1, 2 * ONE);
    it.s_yy = $urandom_range(1, 2 * ONE);
    it.s_xy = srnd(1) / 4;
    return it;
  endfunction

  task automatic push_point();
    in_item_t it;
    int pick;
    pick = $urandom_range(99);
    it = good_point();
    if (pick < 5) it.cam_z = 0;
    else if (pick < 9) it.s_xx = -int'($urandom_range(ONE, 1000 * ONE));
    else if (pick < 11) begin
      it.s_xx = 0; it.s_xy = 0; it.s_yy = 0;
    end else if (pick < 18) it = blank_beat(REQ_POINT);
    beat_q.push_back(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_STOP_COST) stop_lim = val;
    else if (idx == CFG_ROBUST_SCALE) sigma2 = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (beat_q.size() > 0 || in_valid || score_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int n_items);
    int sent, k, i, npts;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(99);
      if (k < 10) begin
        load_table(1'b1);
        sent += 36;
      end else if (k < 18) begin
        push_load($urandom_range(35), $urandom);
        sent++;
      end else if (k < 22) begin
        beat_q.push_back(blank_beat(2'd3));
        push_load($urandom_range(36, 63), $urandom);
      end
      push_start();
      npts = $urandom_range(3, 10);
      for (i = 0; i < npts; i++) push_point();
      sent += npts + 1;
    end
  endtask

  initial begin
    logic [31:0] stop_set[6];
    logic [31:0] sig_set[6];
    in_item_t it;
    int ph;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_took = 1'b0;
    n_errors = 0;
    cycles = 0;
    rx_hold_req = 1'b0;
    rx_hold_cnt = 0;
    cost_acc = '0;
    stop_lim = 32'hFFFFFFFF;
    sigma2 = ONE;
    foreach (coef[i]) coef[i] = 0;
    stop_set = '{32'hFFFFFFFF, 32'h0003_0000, 32'h0, 32'h0005_0000, 32'h0002_0000, 32'hFFFFFFFF};
    sig_set = '{32'h0001_0000, 32'h1, 32'hFFFFFFFF, 32'h0000_4000, 32'h0, 32'h0100_0000};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tx_gap_pct = 12;
    rx_stall_pct = 56;
    load_table(1'b0);
    push_start();
    push_point();
    it = good_point();
    beat_q.push_back(it);
    it.cam_z = 0;
    beat_q.push_back(it);
    it = good_point();
    it.s_xx = 32'h80000000;
    beat_q.push_back(it);
    it = good_point();
    it.s_xx = 0; it.s_xy = 0; it.s_yy = 0;
    beat_q.push_back(it);
    it.ref_x = 32'h7FFFFFFF; it.ref_y = 32'h80000000; it.ref_z = 32'h7FFFFFFF;
    it.cam_x = 32'h80000000; it.cam_y = 32'h7FFFFFFF; it.cam_z = 32'h80000000;
    it.s_xx = 32'h7FFFFFFF; it.s_xy = 32'h80000000; it.s_yy = 32'h7FFFFFFF;
    beat_q.push_back(it);
    it.s_xy = 32'h7FFFFFFF;
    beat_q.push_back(it);
    beat_q.push_back(blank_beat(2'd3));
    push_load(36, 32'h7FFFFFFF);
    push_load(63, 32'h80000000);
    push_start();
    push_point();
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin tx_gap_pct = 12; rx_stall_pct = 56; end
        1: begin tx_gap_pct = 56; rx_stall_pct = 12; end
        default: begin tx_gap_pct = 0; rx_stall_pct = 0; end
      endcase
      write_reg(CFG_STOP_COST, stop_set[ph]);
      write_reg(CFG_ROBUST_SCALE, sig_set[ph]);
      write_reg(2'd2 + ph[0], $urandom);
      random_phase(PHASE_ITEMS);
      if (ph == 1 || ph == 4) rx_hold_req = 1'b1;
      drain();
    end

    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/srrc_pkg.sv
rtl/core/stereo_reprojection_robust_cost_core.sv
dv/testbench.sv
